// ----- src/drba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DRAM row buffer access package
// Shared widths, register indexes, row outcome codes and the row tracker
// result record.
// ----------------------------------------------------------------------------
package drba_pkg;

    localparam int ROW_BYTES   = 1024;
    localparam int ROW_COUNT   = 1024;
    localparam int ADDR_W      = 20;
    localparam int WORD_W      = 32;
    localparam int DELAY_W     = 16;
    localparam int LAT_W       = 18;
    localparam int COUNT_W     = 32;
    localparam int COL_W       = $clog2(ROW_BYTES);
    localparam int ROW_W       = $clog2(ROW_COUNT);
    localparam int WORD_BYTE_W = 2;
    localparam int WIDX_W      = ADDR_W - WORD_BYTE_W;
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_DELAY    = 1'b0,
        CFG_COLUMN_DELAY = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OUTCOME_HIT      = 2'd0,
        OUTCOME_ACTIVATE = 2'd1,
        OUTCOME_CONFLICT = 2'd2
    } outcome_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [LAT_W-1:0]   latency;
        outcome_t           outcome;
        logic [COUNT_W-1:0] total;
    } row_result_t;

endpackage
`default_nettype wire

// ----- src/drba_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DRAM row buffer access channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface drba_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [19:0]        byte_address;
    logic signed [31:0] store_value;

    modport source (output valid, command, byte_address, store_value, input ready);
    modport sink   (input valid, command, byte_address, store_value, output ready);
endinterface

interface drba_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] load_value;
    logic [17:0]        access_latency;
    logic [1:0]         row_outcome;
    logic               misaligned;
    logic [31:0]        buffer_update_total;

    modport source (output valid, load_value, access_latency, row_outcome, misaligned,
                    buffer_update_total, input ready);
    modport sink   (input valid, load_value, access_latency, row_outcome, misaligned,
                    buffer_update_total, output ready);
endinterface
`default_nettype wire

// ----- src/drba_word_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Single-port word RAM
// One access per cycle; read data registered and held until the next read.
// ----------------------------------------------------------------------------
module drba_word_ram #(
    parameter int ADDR_BITS = 18,
    parameter int DATA_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] addr,
    input  wire logic [DATA_BITS-1:0] wdata,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem_reg [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem_reg[addr] <= wdata;
            else
                rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- src/drba_row_track.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Row buffer tracker
// Holds the open row and the update count; classifies each access.
// ----------------------------------------------------------------------------
module drba_row_track (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic                          misaligned,
    input  wire logic [drba_pkg::ROW_W-1:0]    row,
    input  wire logic [drba_pkg::DELAY_W-1:0]  row_delay,
    input  wire logic [drba_pkg::DELAY_W-1:0]  column_delay,
    output drba_pkg::row_result_t              result
);
    import drba_pkg::*;

    logic [ROW_W-1:0]   open_row_reg;
    logic               row_valid_reg;
    logic [COUNT_W-1:0] counter_reg;
    logic [COUNT_W-1:0] counter_next;
    logic [LAT_W-1:0]   rd_ext;
    logic [LAT_W-1:0]   cd_ext;
    logic [1:0]         inc;

    assign rd_ext = {{(LAT_W-DELAY_W){1'b0}}, row_delay};
    assign cd_ext = {{(LAT_W-DELAY_W){1'b0}}, column_delay};

    always_comb
    begin
        priority if (misaligned)
        begin
            result.outcome = OUTCOME_HIT;
            result.latency = '0;
            inc            = 2'd0;
        end
        else if (row_valid_reg && open_row_reg == row)
        begin
            result.outcome = OUTCOME_HIT;
            result.latency = cd_ext;
            inc            = 2'd0;
        end
        else if (!row_valid_reg)
        begin
            result.outcome = OUTCOME_ACTIVATE;
            result.latency = rd_ext + cd_ext;
            inc            = 2'd1;
        end
        else
        begin
            result.outcome = OUTCOME_CONFLICT;
            result.latency = (rd_ext << 1) + cd_ext;
            inc            = 2'd2;
        end
        counter_next = counter_reg + {{(COUNT_W-2){1'b0}}, inc};
        result.total = counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_row_reg  <= '0;
            row_valid_reg <= 1'b0;
            counter_reg   <= '0;
        end
        else if (fire && !misaligned)
        begin
            open_row_reg  <= row;
            row_valid_reg <= 1'b1;
            counter_reg   <= counter_next;
        end
    end

    // once a row opens it stays open
    a_row_stays_open: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid_reg |=> row_valid_reg)
        else $error("open row buffer closed");

    // the update count moves only on an accepted aligned access
    a_counter_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && !misaligned) |=> $stable(counter_reg))
        else $error("update count changed without an access");

endmodule
`default_nettype wire

// ----- src/dram_row_buffer_access_timing.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DRAM row buffer access timing
// Word store behind one open-row buffer with per-access timing and counts.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries one word read or write (command, byte_address,
//   store_value). out_item returns one result per item: load_value,
//   access_latency, row_outcome, misaligned and buffer_update_total.
//   Both channels move an item when valid and ready are high at a clock edge.
//   The cfg port writes row_delay (index 0) and column_delay (index 1); write
//   them only while no item is in flight.
// Timing:
//   Items pass the read stage and output register. With no out_item stall
//   one item per cycle is sustained: the single RAM port does one access per
//   aligned item, and the row tracker sets the outcome in the accept cycle.
// Reset:
//   After rst_n is released the block sweeps the 262144-word store to zero,
//   one word a cycle, so in_item.ready stays low until the sweep ends.
//   Configuration writes are taken during the sweep.
// Stall:
//   A stalled out_item holds its result; one more item is held in the RAM
//   read stage, then in_item.ready drops until the receiver drains.
// ----------------------------------------------------------------------------
module dram_row_buffer_access_timing (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    drba_in_if.sink                            in_item,
    drba_out_if.source                         out_item,
    input  wire logic                          cfg_write_en,
    input  wire logic [drba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [drba_pkg::DELAY_W-1:0]  cfg_data
);
    import drba_pkg::*;

    // configuration
    logic [DELAY_W-1:0] row_delay_reg;
    logic [DELAY_W-1:0] column_delay_reg;

    // clearing sweep and control
    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [WIDX_W-1:0] clr_idx_reg;
    logic              clearing;

    // accept stage
    logic              fire;
    logic              in_misaligned;
    logic [ROW_W-1:0]  in_row;
    logic [WIDX_W-1:0] in_widx;
    row_result_t       row_result;

    // RAM port
    logic              ram_en;
    logic              ram_we;
    logic [WIDX_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    // read stage
    logic              s1_valid_reg;
    row_result_t       s1_result_reg;
    logic              s1_misaligned_reg;
    logic              s1_load_reg;
    logic              advance;

    // output stage
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_load_reg;
    row_result_t       out_result_reg;
    logic              out_misaligned_reg;

    // configuration writes, taken at any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_delay_reg    <= DELAY_W'(10);
            column_delay_reg <= DELAY_W'(2);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROW_DELAY:    row_delay_reg    <= cfg_data;
                CFG_COLUMN_DELAY: column_delay_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clear sweep sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_idx_reg == {WIDX_W{1'b1}}) state_next = ST_RUN;
            ST_RUN:   state_next = ST_RUN;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_idx_reg <= clr_idx_reg + WIDX_W'(1);
        end
    end

    // split the address: column low, row above it, word index drops byte bits
    assign in_misaligned = |in_item.byte_address[WORD_BYTE_W-1:0];
    assign in_row        = in_item.byte_address[COL_W +: ROW_W];
    assign in_widx       = in_item.byte_address[ADDR_W-1:WORD_BYTE_W];

    // advance the read stage when the output register is free or draining
    assign advance       = s1_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready = !clearing && (!s1_valid_reg || advance);
    assign fire          = in_item.valid && in_item.ready;

    drba_row_track u_row_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .misaligned   (in_misaligned),
        .row          (in_row),
        .row_delay    (row_delay_reg),
        .column_delay (column_delay_reg),
        .result       (row_result)
    );

    // the sweep owns the RAM port until the store is zero
    always_comb
    begin
        if (clearing)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_idx_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_en    = fire && !in_misaligned;
            ram_we    = in_item.command;
            ram_addr  = in_widx;
            ram_wdata = in_item.store_value;
        end
    end

    drba_word_ram #(
        .ADDR_BITS (WIDX_W),
        .DATA_BITS (WORD_W)
    ) u_word_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // read stage: hold the access record while the RAM read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (fire)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_result_reg     <= row_result;
            s1_misaligned_reg <= in_misaligned;
            s1_load_reg       <= !in_item.command && !in_misaligned;
        end
    end

    // output register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_item.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_load_reg       <= s1_load_reg ? ram_rdata : '0;
            out_result_reg     <= s1_result_reg;
            out_misaligned_reg <= s1_misaligned_reg;
        end
    end

    assign out_item.valid               = out_valid_reg;
    assign out_item.load_value          = out_load_reg;
    assign out_item.access_latency      = out_result_reg.latency;
    assign out_item.row_outcome         = out_result_reg.outcome;
    assign out_item.misaligned          = out_misaligned_reg;
    assign out_item.buffer_update_total = out_result_reg.total;

    // no item enters while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_item.ready)
        else $error("item accepted during store clear");

    // a dropped access reports no delay and a hit code
    a_misaligned_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_misaligned_reg) |->
            (out_result_reg.latency == '0 && out_result_reg.outcome == OUTCOME_HIT
             && out_load_reg == '0))
        else $error("misaligned result carries timing");

    // a stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item.ready) |=>
            (out_valid_reg && $stable(out_load_reg) && $stable(out_result_reg)
             && $stable(out_misaligned_reg)))
        else $error("stalled result changed");

endmodule
`default_nettype wire
